@@ design/tcce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int OROW_W  = 5;
  localparam int OCOL_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;
  localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF       = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;

  localparam int TAB_STOP = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [4:0]        read_row;
    logic [6:0]        read_col;
  } in_item_t;

  typedef struct packed {
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } res_item_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDWAIT = 4'b0010,
    ST_CLEAR  = 4'b0100,
    ST_FINISH = 4'b1000
  } ctrl_state_t;

endpackage

@@ design/tcce_screen_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_screen_mem
// Screen store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_screen_mem #(
  parameter int DEPTH = 2000
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [tcce_pkg::CELL_W-1:0]  wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [tcce_pkg::CELL_W-1:0]  rdata
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/tcce_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// Cursor, scroll offset and command sequencer; drives the screen store,
// sweeping zero writes for clears.
// ----------------------------------------------------------------------------
module tcce_ctrl #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcce_pkg::in_item_t                  in_item,
  input  logic [tcce_pkg::ATTR_W-1:0]         attr,
  output logic                                res_valid,
  input  logic                                res_ready,
  output tcce_pkg::res_item_t                 res,
  output logic                                mem_we,
  output logic [$clog2(ROWS*COLS)-1:0]        mem_waddr,
  output logic [tcce_pkg::CELL_W-1:0]         mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(ROWS*COLS)-1:0]        mem_raddr,
  input  logic [tcce_pkg::CELL_W-1:0]         mem_rdata
);
  import tcce_pkg::*;

  localparam int TOTAL  = ROWS * COLS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int RS_W   = ((ROW_W > 5) ? ROW_W : 5) + 1;

  ctrl_state_t       state_r, state_nxt;
  logic [ROW_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;     // physical row shown as line 0
  logic [ADDR_W-1:0] swp_addr_r, swp_addr_nxt;
  logic [ADDR_W-1:0] swp_last_r, swp_last_nxt;
  logic              scr_pend_r, scr_pend_nxt;
  logic [ADDR_W-1:0] scr_base_r, scr_base_nxt;
  logic              give_res_r, give_res_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              scrolled_r, scrolled_nxt;

  logic [ROW_W:0]    cur_sum;
  logic [ROW_W-1:0]  cur_phys;
  logic [ADDR_W-1:0] cur_base, cur_addr;
  logic [RS_W-1:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic [ROW_W-1:0]  top_inc;
  logic [ADDR_W-1:0] old_top_base;
  logic              nl_scroll;
  logic [ROW_W-1:0]  nl_line;
  logic [COL_W-1:0]  tab_or;
  logic [COL_W:0]    tab_stop;
  logic              tab_wrap;
  logic [COL_W-1:0]  tab_last;
  logic              printable;

  // logical to physical row: rows rotate on scroll
  always_comb begin
    cur_sum = {1'b0, line_r} + {1'b0, top_r};
    if (cur_sum >= (ROW_W+1)'(ROWS)) begin
      cur_sum = cur_sum - (ROW_W+1)'(ROWS);
    end
    cur_phys = cur_sum[ROW_W-1:0];
    cur_base = ADDR_W'(cur_phys) * ADDR_W'(COLS);
    cur_addr = cur_base + ADDR_W'(col_r);

    rd_in_range = (RS_W'(in_item.read_row) < RS_W'(ROWS)) &&
                  ({1'b0, in_item.read_col} < 8'(COLS));
    rd_sum = RS_W'(in_item.read_row) + RS_W'(top_r);
    if (rd_sum >= RS_W'(ROWS)) begin
      rd_sum = rd_sum - RS_W'(ROWS);
    end
    rd_addr = ADDR_W'(rd_sum) * ADDR_W'(COLS) + ADDR_W'(in_item.read_col);

    top_inc      = (top_r == ROW_W'(ROWS-1)) ? '0 : top_r + ROW_W'(1);
    old_top_base = ADDR_W'(top_r) * ADDR_W'(COLS);

    nl_scroll = (line_r == ROW_W'(ROWS-1));
    nl_line   = nl_scroll ? line_r : line_r + ROW_W'(1);

    tab_or   = col_r | COL_W'(TAB_STOP-1);
    tab_stop = {1'b0, tab_or} + (COL_W+1)'(1);
    tab_wrap = (tab_stop >= (COL_W+1)'(COLS));
    tab_last = tab_wrap ? COL_W'(COLS-1) : tab_or;

    printable = (in_item.ch >= CH_PRINT_LO) && (in_item.ch <= CH_PRINT_HI);
  end

  always_comb begin
    state_nxt    = state_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    swp_addr_nxt = swp_addr_r;
    swp_last_nxt = swp_last_r;
    scr_pend_nxt = scr_pend_r;
    scr_base_nxt = scr_base_r;
    give_res_nxt = give_res_r;
    cell_nxt     = cell_r;
    scrolled_nxt = scrolled_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_addr;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = rd_addr;
    in_ready     = (state_r == ST_IDLE);
    res_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scrolled_nxt = 1'b0;
          cell_nxt     = '0;
          give_res_nxt = 1'b1;
          scr_pend_nxt = 1'b0;
          state_nxt    = ST_FINISH;
          priority if (in_item.op == OP_READ) begin
            if (rd_in_range) begin
              mem_re    = 1'b1;
              state_nxt = ST_RDWAIT;
            end
          end else if (printable) begin
            mem_we    = 1'b1;
            mem_wdata = {attr, in_item.ch};
            if (col_r == COL_W'(COLS-1)) begin
              col_nxt  = '0;
              line_nxt = nl_line;
              if (nl_scroll) begin
                scrolled_nxt = 1'b1;
                top_nxt      = top_inc;
                swp_addr_nxt = old_top_base;
                swp_last_nxt = old_top_base + ADDR_W'(COLS-1);
                state_nxt    = ST_CLEAR;
              end
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
          end else if (in_item.ch == CH_BS) begin
            if (col_r != '0) begin
              col_nxt = col_r - COL_W'(1);
            end
          end else if (in_item.ch == CH_TAB || in_item.ch == CH_LF) begin
            swp_addr_nxt = cur_addr;
            state_nxt    = ST_CLEAR;
            if (in_item.ch == CH_LF || tab_wrap) begin
              swp_last_nxt = cur_base + ADDR_W'(COLS-1);
              col_nxt      = '0;
              line_nxt     = nl_line;
              if (nl_scroll) begin
                scrolled_nxt = 1'b1;
                scr_pend_nxt = 1'b1;
                scr_base_nxt = old_top_base;
                top_nxt      = top_inc;
              end
            end else begin
              swp_last_nxt = cur_base + ADDR_W'(tab_last);
              col_nxt      = tab_stop[COL_W-1:0];
            end
          end else if (in_item.ch == CH_FF) begin
            swp_addr_nxt = '0;
            swp_last_nxt = ADDR_W'(TOTAL-1);
            line_nxt     = '0;
            col_nxt      = '0;
            state_nxt    = ST_CLEAR;
          end else if (in_item.ch == CH_CR) begin
            col_nxt = '0;
          end else begin
            // other control bytes leave everything as it is
          end
        end
      end
      ST_RDWAIT: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_FINISH;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = swp_addr_r;
        if (swp_addr_r == swp_last_r) begin
          if (scr_pend_r) begin
            // second run: the row that scrolled in at the bottom
            swp_addr_nxt = scr_base_r;
            swp_last_nxt = scr_base_r + ADDR_W'(COLS-1);
            scr_pend_nxt = 1'b0;
          end else begin
            state_nxt = give_res_r ? ST_FINISH : ST_IDLE;
          end
        end else begin
          swp_addr_nxt = swp_addr_r + ADDR_W'(1);
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      line_r     <= '0;
      col_r      <= '0;
      top_r      <= '0;
      swp_addr_r <= '0;
      swp_last_r <= ADDR_W'(TOTAL-1);
      scr_pend_r <= 1'b0;
      give_res_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      top_r      <= top_nxt;
      swp_addr_r <= swp_addr_nxt;
      swp_last_r <= swp_last_nxt;
      scr_pend_r <= scr_pend_nxt;
      give_res_r <= give_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scr_base_r <= scr_base_nxt;
    cell_r     <= cell_nxt;
    scrolled_r <= scrolled_nxt;
  end

  assign res.cursor_row = OROW_W'(line_r);
  assign res.cursor_col = OCOL_W'(col_r);
  assign res.cell_data  = cell_r;
  assign res.scrolled   = scrolled_r;

`ifndef SYNTHESIS
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ((COL_W+1)'(col_r) < (COL_W+1)'(COLS)) && ((ROW_W+1)'(line_r) < (ROW_W+1)'(ROWS)))
    else $error("cursor outside screen");

  a_top_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_W+1)'(top_r) < (ROW_W+1)'(ROWS))
    else $error("scroll offset outside screen");

  a_rdwait_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDWAIT) |-> $past(mem_re))
    else $error("read wait without a read issued");

  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_CLEAR) |-> (in_valid && in_ready))
    else $error("store written outside a beat or clear");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (swp_addr_r <= swp_last_r))
    else $error("clear sweep ran past its end");
`endif

endmodule

@@ design/text_console_char_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text console: screen store of 16-bit cells, internal cursor, scrolling.
// ----------------------------------------------------------------------------
// Flow: BS, CR, other bytes, out-of-screen reads and printables that do not
//   scroll go through the finish state; in-screen reads first pass read-wait.
// Tab and newline sweep zero writes over the cleared cells; any scroll (a
//   printable wrapping off the last line included) also clears a row, and
//   form feed clears all cells. Throughput: one item at a time.
// Reset: synchronous; store cleared by a full sweep before the first beat is
//   accepted. Configuration writes are taken at any time.
module text_console_char_engine #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // ch[7:0] read_row[12:8] read_col[19:13]
  input  logic                               in_tuser,   // op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // cursor_row[4:0] cursor_col[11:5]
                                                         // cell_data[27:12] scrolled[28]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcce_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import tcce_pkg::*;

  localparam int TOTAL  = ROWS * COLS;
  localparam int ADDR_W = $clog2(TOTAL);

  logic              blink_r;
  logic [2:0]        back_r;
  logic [3:0]        fore_r;
  in_item_t          item;
  res_item_t         res;
  logic              res_valid, res_ready;
  logic              out_valid_r;
  res_item_t         out_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_r <= 1'b0;
      back_r  <= 3'd0;
      fore_r  <= 4'd15;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BLINK) begin
        blink_r <= cfg_data[0];
      end
      if (cfg_index == CFG_BACK) begin
        back_r <= cfg_data[2:0];
      end
      if (cfg_index == CFG_FORE) begin
        fore_r <= cfg_data;
      end
    end
  end

  assign item.op       = in_tuser;
  assign item.ch       = in_tdata[7:0];
  assign item.read_row = in_tdata[12:8];
  assign item.read_col = in_tdata[19:13];

  tcce_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .attr      ({blink_r, back_r, fore_r}),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcce_screen_mem #(
    .DEPTH (TOTAL)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.scrolled, out_r.cell_data,
                       out_r.cursor_col, out_r.cursor_row};

endmodule
